>>> src/pbb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package pbb_pkg;

  localparam int GFX_WORDS_DEF = 65536;
  // wide enough for src*4 and for the largest store size
  localparam int RED_W = 19;

  localparam logic [1:0] CMD_CPU  = 2'd0;
  localparam logic [1:0] CMD_LOAD = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;
  localparam logic [1:0] CMD_RSVD = 2'd3;

  localparam logic [15:0] WIN_PLANE_MASK = 16'hC000;
  localparam logic [15:0] WIN_PLANE      = 16'h8000;
  localparam logic [15:0] WIN_REG_MASK   = 16'hF000;
  localparam logic [15:0] WIN_REG        = 16'hE000;
  localparam logic [2:0]  REG_PLANE      = 3'd0;
  localparam logic [2:0]  REG_SRC_LO     = 3'd1;
  localparam logic [2:0]  REG_SRC_HI     = 3'd2;
  localparam logic [2:0]  REG_Y          = 3'd3;
  localparam logic [2:0]  REG_X4         = 3'd4;
  localparam logic [2:0]  REG_H          = 3'd5;
  localparam logic [2:0]  REG_BLIT_W     = 3'd6;
  localparam logic [3:0]  NIB_TRANSP     = 4'h8;

  typedef struct packed {
    logic latch;
    logic reg_wr;
    logic clr_step;
    logic red_init_ld;
    logic red_init_blit;
    logic red_step;
    logic pos_load;
    logic pw_rd;
    logic pw_wr;
    logic gfx_wr;
    logic gfx_rd;
    logic bl_rd;
    logic bl_wr;
    logic adv;
    logic rd_rd;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       plane_win;
    logic       reg_win;
    logic       reg_blit;
    logic       clr_done;
    logic       red_done;
    logic       pw_last;
    logic       nib_skip;
    logic       blit_last;
    logic       out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> src/pbb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module pbb_ctrl import pbb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_PW_RD  = 4'd3;
  localparam logic [3:0] S_PW_WR  = 4'd4;
  localparam logic [3:0] S_LD_RED = 4'd5;
  localparam logic [3:0] S_BL_RED = 4'd6;
  localparam logic [3:0] S_BL_GRD = 4'd7;
  localparam logic [3:0] S_BL_CHK = 4'd8;
  localparam logic [3:0] S_BL_WR  = 4'd9;
  localparam logic [3:0] S_RD_RD  = 4'd10;
  localparam logic [3:0] S_RD_OUT = 4'd11;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        state_nxt = S_IDLE;
        unique case (stat.cmd)
          CMD_CPU: begin
            if (stat.plane_win) begin
              state_nxt = S_PW_RD;
            end else if (stat.reg_win) begin
              cmd.reg_wr = 1'b1;
              if (stat.reg_blit) begin
                cmd.red_init_blit = 1'b1;
                state_nxt = S_BL_RED;
              end
            end
          end
          CMD_LOAD: begin
            cmd.red_init_ld = 1'b1;
            state_nxt = S_LD_RED;
          end
          CMD_READ: state_nxt = S_RD_RD;
          default: state_nxt = S_IDLE;
        endcase
      end
      S_PW_RD: begin
        cmd.pw_rd = 1'b1;
        state_nxt = S_PW_WR;
      end
      S_PW_WR: begin
        cmd.pw_wr = 1'b1;
        state_nxt = stat.pw_last ? S_IDLE : S_PW_RD;
      end
      S_LD_RED: begin
        if (stat.red_done) begin
          cmd.gfx_wr = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_BL_RED: begin
        if (stat.red_done) begin
          cmd.pos_load = 1'b1;
          state_nxt = S_BL_GRD;
        end else begin
          cmd.red_step = 1'b1;
        end
      end
      S_BL_GRD: begin
        cmd.gfx_rd = 1'b1;
        state_nxt = S_BL_CHK;
      end
      S_BL_CHK: begin
        if (stat.nib_skip) begin
          cmd.adv = 1'b1;
          state_nxt = stat.blit_last ? S_IDLE : S_BL_GRD;
        end else begin
          cmd.bl_rd = 1'b1;
          state_nxt = S_BL_WR;
        end
      end
      S_BL_WR: begin
        cmd.bl_wr = 1'b1;
        cmd.adv = 1'b1;
        state_nxt = stat.blit_last ? S_IDLE : S_BL_GRD;
      end
      S_RD_RD: begin
        cmd.rd_rd = 1'b1;
        state_nxt = S_RD_OUT;
      end
      S_RD_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/pbb_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module pbb_datapath import pbb_pkg::*; #(
  parameter int GFX_WORDS = GFX_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  input  wire logic        out_ready,
  output logic             out_valid,
  output logic [7:0]       out_pixel,
  input  wire ctl_cmd_t    cmd,
  output dp_stat_t         stat
);

  localparam int GA_W = $clog2(GFX_WORDS);
  localparam logic [RED_W-1:0] GW = RED_W'(GFX_WORDS);
  localparam logic [GA_W-1:0] GA_LAST = GA_W'(GFX_WORDS - 1);

  logic [1:0]  cmd_r;
  logic [15:0] addr_r;
  logic [7:0]  data_r;
  logic [7:0]  blit_regs_r [8];
  logic [15:0] clr_cnt_r;
  logic [RED_W-1:0] red_r;
  logic [GA_W-1:0]  pos_r;
  logic [1:0]  k_r, pw_i_r;
  logic [7:0]  j_r, i_r;
  logic [5:0]  x_r;
  logic [7:0]  bm_q;
  logic [3:0]  gfx_q;
  logic        out_valid_r;
  logic [7:0]  out_pixel_r;

  logic [7:0]  bitmap_mem [65536];
  logic [3:0]  gfx_mem [GFX_WORDS];

  logic [15:0] pw_addr, bl_idx, bm_ra, bm_wa;
  logic [7:0]  pw_mod, bl_mod, bm_wd, row;
  logic        bm_we, bm_re;
  logic [1:0]  pair;
  logic [7:0]  mask;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      cmd_r  <= in_cmd;
      addr_r <= in_address;
      data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < 8; r++) blit_regs_r[r] <= '0;
    end else if (cmd.reg_wr) begin
      blit_regs_r[addr_r[2:0]] <= data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + 16'd1;
    end
  end

  // modulo by repeated subtraction of the store size
  always_ff @(posedge clk) begin
    if (cmd.red_init_ld) begin
      red_r <= RED_W'(addr_r);
    end else if (cmd.red_init_blit) begin
      red_r <= RED_W'({blit_regs_r[2], blit_regs_r[1], 2'b00});
    end else if (cmd.red_step) begin
      red_r <= red_r - GW;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (cmd.pos_load) begin
      pos_r <= red_r[GA_W-1:0];
    end else if (cmd.adv) begin
      pos_r <= (pos_r == GA_LAST) ? '0 : pos_r + GA_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= '0;
      j_r <= '0;
      i_r <= '0;
      x_r <= '0;
    end else if (cmd.red_init_blit) begin
      k_r <= '0;
      j_r <= '0;
      i_r <= '0;
      x_r <= blit_regs_r[4][5:0];
    end else if (cmd.adv) begin
      k_r <= k_r + 2'd1;
      if (k_r == 2'd3) begin
        if (j_r == blit_regs_r[5]) begin
          j_r <= '0;
          i_r <= i_r + 8'd1;
          x_r <= x_r + 6'd1;
        end else begin
          j_r <= j_r + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pw_i_r <= '0;
    end else if (cmd.latch) begin
      pw_i_r <= '0;
    end else if (cmd.pw_wr) begin
      pw_i_r <= pw_i_r + 2'd1;
    end
  end

  assign pw_addr = {addr_r[7:0], addr_r[13:8], pw_i_r};
  assign row     = blit_regs_r[3] + j_r;
  // nibble k lands on pixel 4*x+3-k
  assign bl_idx  = {row, x_r, ~k_r};
  assign mask    = blit_regs_r[0];

  always_comb begin
    pair   = {data_r[3'd4 + {1'b0, pw_i_r}], data_r[{1'b0, pw_i_r}]};
    pw_mod = bm_q;
    for (int k = 0; k < 4; k++) begin
      if (mask[3-k]) pw_mod[2*k +: 2] = pair;
    end
  end

  always_comb begin
    bl_mod = bm_q;
    if (mask[0]) bl_mod[7:4] = gfx_q;
    if (mask[2]) bl_mod[3:0] = gfx_q;
  end

  always_comb begin
    bm_re = cmd.pw_rd | cmd.bl_rd | cmd.rd_rd;
    priority if (cmd.pw_rd) bm_ra = pw_addr;
    else if (cmd.bl_rd) bm_ra = bl_idx;
    else bm_ra = addr_r;
    bm_we = cmd.clr_step | cmd.pw_wr | cmd.bl_wr;
    priority if (cmd.clr_step) begin
      bm_wa = clr_cnt_r;
      bm_wd = '0;
    end else if (cmd.pw_wr) begin
      bm_wa = pw_addr;
      bm_wd = pw_mod;
    end else begin
      bm_wa = bl_idx;
      bm_wd = bl_mod;
    end
  end

  always_ff @(posedge clk) begin
    if (bm_we) bitmap_mem[bm_wa] <= bm_wd;
    if (bm_re) bm_q <= bitmap_mem[bm_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.gfx_wr) gfx_mem[red_r[GA_W-1:0]] <= data_r[3:0];
    if (cmd.gfx_rd) gfx_q <= gfx_mem[pos_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_pixel_r <= bm_q;
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  always_comb begin
    stat.cmd       = cmd_r;
    stat.plane_win = (addr_r & WIN_PLANE_MASK) == WIN_PLANE;
    stat.reg_win   = (addr_r & WIN_REG_MASK) == WIN_REG;
    stat.reg_blit  = addr_r[2:0] == REG_BLIT_W;
    stat.clr_done  = clr_cnt_r == 16'hFFFF;
    stat.red_done  = red_r < GW;
    stat.pw_last   = pw_i_r == 2'd3;
    stat.nib_skip  = gfx_q == NIB_TRANSP;
    stat.blit_last = (k_r == 2'd3) && (j_r == blit_regs_r[5]) && (i_r == blit_regs_r[6]);
    stat.out_free  = !out_valid_r || out_ready;
  end

`ifndef SYNTHESIS
  a_gfx_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gfx_wr |-> red_r < GW) else $error("graphics write address not reduced");
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    RED_W'(pos_r) < GW) else $error("graphics read pointer out of range");
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready)) else $error("result overwritten");
`endif

endmodule
`default_nettype wire

>>> src/planar_bitmap_blitter.sv
`timescale 1ns / 1ps
`default_nettype none
// Video write path of a 256x256 byte bitmap. After reset the bitmap is swept
// to zero, one pixel per cycle, and no transaction is taken until that
// finishes. Each transaction is then handled alone: a plane write does a
// read-modify-write of four pixels through the bitmap's one read and one write
// port, a register write stores one byte, a graphics load reduces its address
// by repeated subtraction of the store size, and a pixel read waits until the
// output register is free. A blit (write of register 6) first reduces src*4
// modulo GFX_WORDS, then walks 4*(w+1)*(h+1) nibbles, each a gfx read and,
// unless transparent, a bitmap read and bitmap write done in turn.
module planar_bitmap_blitter import pbb_pkg::*; #(
  parameter int GFX_WORDS = GFX_WORDS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [15:0] in_address,
  input  wire logic [7:0]  in_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_pixel
);

  ctl_cmd_t ctl;
  dp_stat_t stat;

  pbb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (ctl)
  );

  pbb_datapath #(.GFX_WORDS(GFX_WORDS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_cmd     (in_cmd),
    .in_address (in_address),
    .in_data    (in_data),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_pixel  (out_pixel),
    .cmd        (ctl),
    .stat       (stat)
  );

endmodule
`default_nettype wire
